[rtl/fp8_e4m3fn_converter_top_macros.svh]
// assertion macros for the fp8 converter
`ifndef FP8_E4M3FN_CONVERTER_TOP_MACROS_SVH
`define FP8_E4M3FN_CONVERTER_TOP_MACROS_SVH

// assert that a condition implies a consequence in the same cycle
`define F8C_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// assert that a condition implies a consequence in the next cycle
`define F8C_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/f8c_pkg.sv]
`default_nettype none
package f8c_pkg;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  localparam logic [6:0] FP8_SAT = 7'h7e;
  localparam logic [6:0] FP8_NAN = 7'h7f;
  localparam logic [30:0] FLT_INF_MAG = 31'h7f800000;
  localparam logic [30:0] FLT_448_MAG = 31'h43e00000;
  localparam logic [30:0] FLT_QNAN_MAG = 31'h7fc00000;

  typedef struct packed {
    logic        action;
    logic [31:0] float_bits;
    logic [7:0]  fp8_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  fp8_result;
    logic [31:0] float_result;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/fp8_e4m3fn_converter_top.sv]
// start loads the input register; the result register then drives out_item and out_valid
// throughput: one item per cycle; busy is always low
// the result strobe lasts one cycle and cannot be held off by the receiver
// synchronous active-low reset clears the valid flags; data registers are not reset
`default_nettype none
`include "fp8_e4m3fn_converter_top_macros.svh"
module fp8_e4m3fn_converter_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire f8c_pkg::in_item_t in_item,
  output logic                  out_valid,
  output f8c_pkg::out_item_t    out_item
);
  import f8c_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;
  logic [7:0]  enc;
  logic [31:0] dec;
  out_item_t out_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) in_r <= in_item;
    if (in_vld_r) out_r <= out_nxt;
  end

  f8c_encode u_enc (.float_bits(in_r.float_bits), .fp8_result(enc));
  f8c_decode u_dec (.fp8_code(in_r.fp8_code), .float_result(dec));

  always_comb begin
    if (in_r.action == ACT_DECODE) out_nxt = '{fp8_result: 8'd0, float_result: dec};
    else                           out_nxt = '{fp8_result: enc, float_result: 32'd0};
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  `F8C_ASSERT_NEXT(a_pipe, start, in_vld_r)
  `F8C_ASSERT_NEXT(a_out, in_vld_r, out_valid)
  `F8C_ASSERT_NOW(a_excl, out_valid, out_item.fp8_result == 8'd0 || out_item.float_result == 32'd0)
endmodule
`default_nettype wire

[rtl/f8c_encode.sv]
`default_nettype none
module f8c_encode (
  input  wire logic [31:0] float_bits,
  output logic [7:0]       fp8_result
);
  import f8c_pkg::*;

  logic [30:0] mag;
  logic [7:0]  e;
  logic [3:0]  sig;
  logic [4:0]  sh;
  logic [3:0]  q;
  logic        rnd;
  logic        half;
  logic        sticky;
  logic [24:0] ext;
  logic [6:0]  norm;
  logic [6:0]  sub;

  always_comb begin
    mag  = float_bits[30:0];
    e    = mag[30:23];
    // normal codes: keep 3 mantissa bits, round on bit 19 with sticky below
    half   = mag[19];
    sticky = |mag[18:0];
    rnd    = half & (sticky | mag[20]);
    norm   = {e[3:0] + 4'd8, mag[22:20]} + {6'd0, rnd};
    // subnormal codes: shift 1.m right so that the 2^-9 unit lands at bit 0
    ext = {1'b1, mag[22:0], 1'b0};
    sh  = 5'(8'd121 - e);
    sig = 4'(ext >> (5'd21 + 5'(sh)));
    q   = sig;
    half = 1'b0;
    sticky = 1'b0;
    sub = 7'd0;
    if (e < 8'd121 && e > 8'd116) begin
      // bits below the result: ext[20+sh:0]
      half   = ext[5'(5'd20 + sh)];
      sticky = |(ext & ((25'd1 << (5'd20 + sh)) - 25'd1));
      sub    = {3'd0, q} + {6'd0, half & (sticky | q[0])};
    end
    if (mag > FLT_INF_MAG)       fp8_result = {float_bits[31], FP8_NAN};
    else if (mag >= FLT_448_MAG) fp8_result = {float_bits[31], FP8_SAT};
    else if (e >= 8'd121)        fp8_result = {float_bits[31], norm};
    else                         fp8_result = {float_bits[31], sub};
  end
endmodule
`default_nettype wire

[rtl/f8c_decode.sv]
`default_nettype none
module f8c_decode (
  input  wire logic [7:0] fp8_code,
  output logic [31:0]     float_result
);
  import f8c_pkg::*;

  logic [3:0] ex;
  logic [2:0] m;

  always_comb begin
    ex = fp8_code[6:3];
    m  = fp8_code[2:0];
    if (fp8_code[6:0] == FP8_NAN) begin
      float_result = {fp8_code[7], FLT_QNAN_MAG};
    end else if (ex != 4'd0) begin
      float_result = {fp8_code[7], 8'(ex) + 8'd120, m, 20'd0};
    end else if (m[2]) begin
      float_result = {fp8_code[7], 8'd120, m[1:0], 21'd0};
    end else if (m[1]) begin
      float_result = {fp8_code[7], 8'd119, m[0], 22'd0};
    end else if (m[0]) begin
      float_result = {fp8_code[7], 8'd118, 23'd0};
    end else begin
      float_result = {fp8_code[7], 31'd0};
    end
  end
endmodule
`default_nettype wire

[sim/fp8_e4m3fn_converter_top_tb.sv]
`default_nettype none
module fp8_e4m3fn_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import f8c_pkg::*;

  localparam int N_RANDOM = 1230;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  out_item_t pending_q[$];
  int errors = 0;
  int cycles = 0;

  fp8_e4m3fn_converter_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round to nearest even after dropping sh low bits
  function automatic logic [31:0] rne_shift(logic [31:0] sig, int sh);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    if (sh > 31) sh = 31;
    q = sig >> sh;
    rem = sig & ((32'd1 << sh) - 32'd1);
    half = 32'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 32'd1;
    return q;
  endfunction

  function automatic logic [7:0] fp32_to_e4m3(logic [31:0] f);
    logic [7:0] sgn;
    logic [30:0] mag;
    logic [7:0] e;
    logic [31:0] sig;
    logic [31:0] n;
    sgn = {f[31], 7'd0};
    mag = f[30:0];
    e = mag[30:23];
    if (mag > FLT_INF_MAG) return sgn | {1'b0, FP8_NAN};
    if (mag >= FLT_448_MAG) return sgn | {1'b0, FP8_SAT};
    if (e == 8'd0) return sgn;
    sig = {9'd1, mag[22:0]};
    if (e >= 8'd121) begin
      n = rne_shift(sig, 20);
      return sgn | 8'(((32'(e) - 32'd120) << 3) + n - 32'd8);
    end
    n = rne_shift(sig, 141 - int'(e));
    return sgn | 8'(n);
  endfunction

  function automatic logic [31:0] e4m3_to_fp32(logic [7:0] c);
    logic [31:0] sgn;
    logic [3:0] ex;
    logic [2:0] m;
    int p;
    sgn = {c[7], 31'd0};
    ex = c[6:3];
    m = c[2:0];
    if (c[6:0] == FP8_NAN) return sgn | {1'b0, FLT_QNAN_MAG};
    if (ex != 4'd0) return sgn | ((32'(ex) + 32'd120) << 23) | (32'(m) << 20);
    if (m == 3'd0) return sgn;
    p = (m >= 3'd4) ? 2 : ((m >= 3'd2) ? 1 : 0);
    return sgn | (32'(118 + p) << 23) | ((32'(m) - (32'd1 << p)) << (23 - p));
  endfunction

  function automatic out_item_t convert(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.action == ACT_ENCODE) r.fp8_result = fp32_to_e4m3(it.float_bits);
    else r.float_result = e4m3_to_fp32(it.fp8_code);
    return r;
  endfunction

  // directed rows; chk marks rows whose result is typed in
  typedef struct {
    in_item_t item;
    logic chk;
    out_item_t res;
  } row_t;

  row_t rows[] = '{
    '{'{ACT_ENCODE, 32'h7fc00000, 8'hff}, 1'b1, '{8'h7f, 32'h0}},
    '{'{ACT_ENCODE, 32'hff800001, 8'h00}, 1'b1, '{8'hff, 32'h0}},
    '{'{ACT_ENCODE, 32'h7f800000, 8'h00}, 1'b1, '{8'h7e, 32'h0}},
    '{'{ACT_ENCODE, 32'hff800000, 8'h00}, 1'b1, '{8'hfe, 32'h0}},
    '{'{ACT_ENCODE, 32'h43e00000, 8'h00}, 1'b1, '{8'h7e, 32'h0}},
    '{'{ACT_ENCODE, 32'h43dfffff, 8'h00}, 1'b0, '{8'h00, 32'h0}},
    '{'{ACT_ENCODE, 32'h00000000, 8'hff}, 1'b1, '{8'h00, 32'h0}},
    '{'{ACT_ENCODE, 32'h80000000, 8'h00}, 1'b1, '{8'h80, 32'h0}},
    '{'{ACT_ENCODE, 32'h007fffff, 8'h00}, 1'b1, '{8'h00, 32'h0}},
    '{'{ACT_ENCODE, 32'h3a800000, 8'h00}, 1'b1, '{8'h00, 32'h0}},
    '{'{ACT_ENCODE, 32'hba800000, 8'h00}, 1'b1, '{8'h80, 32'h0}},
    '{'{ACT_ENCODE, 32'h3a800001, 8'h00}, 1'b0, '{8'h00, 32'h0}},
    '{'{ACT_ENCODE, 32'h3b000000, 8'h00}, 1'b1, '{8'h01, 32'h0}},
    '{'{ACT_ENCODE, 32'h3f800000, 8'h00}, 1'b1, '{8'h38, 32'h0}},
    '{'{ACT_ENCODE, 32'h3f880000, 8'h00}, 1'b0, '{8'h00, 32'h0}},
    '{'{ACT_ENCODE, 32'h3c7fffff, 8'h00}, 1'b0, '{8'h00, 32'h0}},
    '{'{ACT_DECODE, 32'hffffffff, 8'h7f}, 1'b1, '{8'h00, 32'h7fc00000}},
    '{'{ACT_DECODE, 32'h00000000, 8'hff}, 1'b1, '{8'h00, 32'hffc00000}},
    '{'{ACT_DECODE, 32'h00000000, 8'h00}, 1'b1, '{8'h00, 32'h00000000}},
    '{'{ACT_DECODE, 32'h00000000, 8'h80}, 1'b1, '{8'h00, 32'h80000000}},
    '{'{ACT_DECODE, 32'h00000000, 8'h7e}, 1'b1, '{8'h00, 32'h43e00000}},
    '{'{ACT_DECODE, 32'h00000000, 8'h01}, 1'b1, '{8'h00, 32'h3b000000}},
    '{'{ACT_DECODE, 32'h00000000, 8'h87}, 1'b0, '{8'h00, 32'h0}},
    '{'{ACT_DECODE, 32'h00000000, 8'h38}, 1'b1, '{8'h00, 32'h3f800000}}
  };

  task automatic send(in_item_t it, out_item_t want, int idle_max);
    int gap;
    if (idle_max > 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, idle_max);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(want);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    logic [7:0] ex;
    it.action = 1'($urandom_range(0, 1));
    it.float_bits = $urandom;
    it.fp8_code = 8'($urandom);
    // steer most encodes into and around the code's range
    if (it.action == ACT_ENCODE && $urandom_range(0, 3) != 0) begin
      ex = 8'($urandom_range(110, 137));
      it.float_bits[30:23] = ex;
      if ($urandom_range(0, 3) == 0) it.float_bits[19:0] = ($urandom_range(0, 1) != 0) ?
          20'h80000 : 20'h0;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_item.fp8_result !== want.fp8_result) begin
          $display("%0t: fp8_result expected %h actual %h", $time,
                   want.fp8_result, out_item.fp8_result);
          errors++;
        end
        if (out_item.float_result !== want.float_result) begin
          $display("%0t: float_result expected %h actual %h", $time,
                   want.float_result, out_item.float_result);
          errors++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("fp8_e4m3fn_converter_top_tb: errors");
      $finish;
    end
  end

  initial begin
    int drain;
    out_item_t want;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) begin
      want = convert(rows[i].item);
      if (rows[i].chk && want != rows[i].res) begin
        $display("%0t: table row %0d expected %h predicted %h", $time, i,
                 rows[i].res, want);
        errors++;
      end
      send(rows[i].item, rows[i].chk ? rows[i].res : want, 5);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      in_item_t it;
      it = random_item();
      send(it, convert(it), (i < N_RANDOM - 150) ? 5 : 0);
    end
    start <= 1'b0;
    drain = 0;
    while (pending_q.size() != 0 && drain < 100) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("fp8_e4m3fn_converter_top_tb: clean");
    end else begin
      $display("fp8_e4m3fn_converter_top_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
